// ===== rtl/plob_pkg.sv =====
package plob_pkg;

	// Default number of price levels held per side.
	localparam int unsigned LEVELS_DEF = 64;

	// Most levels per side that one read reports.
	localparam int unsigned READ_MAX = 16;

	// Reset value of the top_depth register.
	localparam logic [4:0] TOP_DEPTH_RST = 5'd5;

	// Action codes.
	localparam logic [2:0] ACT_CLEAR  = 3'd0;
	localparam logic [2:0] ACT_SET    = 3'd1;
	localparam logic [2:0] ACT_UPDATE = 3'd2;
	localparam logic [2:0] ACT_DELETE = 3'd3;
	localparam logic [2:0] ACT_READ   = 3'd4;

	// Status codes.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_PRICE = 3'd1;
	localparam logic [2:0] ST_BAD_QTY   = 3'd2;
	localparam logic [2:0] ST_CROSSED   = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;
	localparam logic [2:0] ST_EMPTY     = 3'd5;

	// One stored price level, price in the lowest bits.
	typedef struct packed {
		logic [15:0] orders;
		logic [31:0] quantity;
		logic [31:0] price;
	} level_t;

endpackage

// ===== rtl/price_level_order_book_top.sv =====
// Channel  | Direction | Beat contents
// s_*      | in        | tuser: action[2:0], side[3]; tdata: price, quantity, orders
// m_*      | out       | tuser: status[2:0], out_side[3]; tdata: level_index, price,
//          |           | quantity, orders; tlast: last
// cfg_*    | in        | top_depth, written when cfg_we is high
//
// Input beats are taken one at a time, only while the sequencer is idle; an action
// that needs no memory work goes through the emit state and straight back to idle.
// Both sides live in one memory with a registered read; the search walks the side
// one level at a time, a read and then a compare, and an insert or delete then moves
// each level behind the position with a read and then a write per level.
// A read issues, waits for and emits each reported level in turn, bids first, then asks.
// No clearing pass: reset and the clear action zero the used counts and leave the memory as is.
// Output stalls hold the sequencer; a finished beat waits in the output register.
module price_level_order_book_top
	import plob_pkg::*;
#(
	parameter int unsigned LEVELS = LEVELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // price[31:0], quantity[63:32], orders[79:64]
	input  logic [3:0]  s_tuser,   // action[2:0], side[3]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // level_index[3:0], price[35:4], quantity[67:36], orders[83:68]
	output logic [3:0]  m_tuser,   // status[2:0], out_side[3]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata
);

	localparam int unsigned IW = $clog2(LEVELS);
	localparam int unsigned CW = $clog2(LEVELS + 1);
	localparam int unsigned MW = (CW > 5) ? CW : 5;
	localparam int unsigned DEPTH = 2 ** (IW + 1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SRCH   = 4'd1;
	localparam logic [3:0] S_SCMP   = 4'd2;
	localparam logic [3:0] S_DEC    = 4'd3;
	localparam logic [3:0] S_SHD_RD = 4'd4;
	localparam logic [3:0] S_SHD_WR = 4'd5;
	localparam logic [3:0] S_SHU_RD = 4'd6;
	localparam logic [3:0] S_SHU_WR = 4'd7;
	localparam logic [3:0] S_EMIT   = 4'd8;
	localparam logic [3:0] S_RD_ISS = 4'd9;
	localparam logic [3:0] S_RD_WT  = 4'd10;

	logic [3:0] state_q;
	logic [4:0] top_depth_q;
	logic [CW-1:0] bid_used_q, ask_used_q;
	logic [31:0] best_bid_q, best_ask_q;

	// Current operation.
	logic        side_q, is_rm_q;
	level_t      item_q;
	logic [CW-1:0] j_q, pos_q, dst_q;
	logic        match_q;

	// Pending result.
	logic [2:0]  res_status_q;
	logic        res_side_q, res_last_q, res_cont_q;
	logic [3:0]  res_idx_q;
	level_t      res_lvl_q;

	// Read sequencing.
	logic        rside_q;
	logic [4:0]  ri_q, nb_q, na_q;

	// Output register.
	logic        m_valid_q;
	logic [87:0] m_data_q;
	logic [3:0]  m_user_q;
	logic        m_last_q;

	// Memory ports.
	level_t mem_q [DEPTH];
	level_t rd_data_q;
	logic   rd_en, wr_en;
	logic [IW:0] rd_addr, wr_addr;
	level_t wr_data;

	logic [2:0]  in_action;
	logic        in_side;
	level_t      in_lvl;
	logic [CW-1:0] used_sel;
	logic [4:0]  depth_eff, nb_c, na_c;
	logic        slot_free, better, accept;

	assign in_action = s_tuser[2:0];
	assign in_side   = s_tuser[3];
	assign in_lvl    = s_tdata;
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign slot_free = !m_valid_q || m_tready;
	assign used_sel  = side_q ? ask_used_q : bid_used_q;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;
	assign m_tlast  = m_last_q;

	// Effective read depth and level counts per side.
	always_comb begin
		if (top_depth_q == 5'd0) begin
			depth_eff = 5'd1;
		end else if (top_depth_q > 5'(READ_MAX)) begin
			depth_eff = 5'(READ_MAX);
		end else begin
			depth_eff = top_depth_q;
		end
		nb_c = (MW'(bid_used_q) < MW'(depth_eff)) ? 5'(bid_used_q) : depth_eff;
		na_c = (MW'(ask_used_q) < MW'(depth_eff)) ? 5'(ask_used_q) : depth_eff;
	end

	// A stored level is strictly better than the searched price.
	assign better = side_q ? (rd_data_q.price < item_q.price)
	                       : (rd_data_q.price > item_q.price);

	// Memory access selection from the sequencer state.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = {side_q, pos_q[IW-1:0]};
		wr_data = item_q;
		case (state_q)
			S_SRCH: begin
				rd_en   = (j_q < used_sel);
				rd_addr = {side_q, j_q[IW-1:0]};
			end
			S_DEC: begin
				wr_en = !is_rm_q && match_q;
			end
			S_SHD_RD: begin
				rd_en   = (dst_q + CW'(1)) < used_sel;
				rd_addr = {side_q, dst_q[IW-1:0] + IW'(1)};
			end
			S_SHD_WR: begin
				wr_en   = 1'b1;
				wr_addr = {side_q, dst_q[IW-1:0]};
				wr_data = rd_data_q;
			end
			S_SHU_RD: begin
				rd_en   = dst_q > pos_q;
				rd_addr = {side_q, dst_q[IW-1:0] - IW'(1)};
				wr_en   = !(dst_q > pos_q);
			end
			S_SHU_WR: begin
				wr_en   = 1'b1;
				wr_addr = {side_q, dst_q[IW-1:0]};
				wr_data = rd_data_q;
			end
			S_RD_ISS: begin
				rd_en   = 1'b1;
				rd_addr = {rside_q, IW'(ri_q)};
			end
			default: begin
			end
		endcase
	end

	// Level memory, one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// Cached best price of each side, following writes to rank zero.
	always_ff @(posedge clk) begin
		if (wr_en && wr_addr[IW-1:0] == '0) begin
			if (wr_addr[IW]) begin
				best_ask_q <= wr_data.price;
			end else begin
				best_bid_q <= wr_data.price;
			end
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_depth_q <= TOP_DEPTH_RST;
		end else if (cfg_we) begin
			top_depth_q <= cfg_wdata;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && slot_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && slot_free) begin
			m_data_q <= {4'd0, res_lvl_q, res_idx_q};
			m_user_q <= {res_side_q, res_status_q};
			m_last_q <= res_last_q;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			bid_used_q <= '0;
			ask_used_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						side_q       <= in_side;
						item_q       <= in_lvl;
						res_side_q   <= in_side;
						res_idx_q    <= '0;
						res_lvl_q    <= '0;
						res_last_q   <= 1'b1;
						res_cont_q   <= 1'b0;
						res_status_q <= ST_OK;
						j_q          <= '0;
						is_rm_q      <= 1'b0;
						state_q      <= S_EMIT;
						case (in_action)
							ACT_CLEAR: begin
								bid_used_q <= '0;
								ask_used_q <= '0;
								res_side_q <= 1'b0;
							end
							ACT_SET, ACT_UPDATE: begin
								if (in_action == ACT_UPDATE && in_lvl.quantity == '0) begin
									is_rm_q <= 1'b1;
									state_q <= S_SRCH;
								end else if (in_lvl.price == '0) begin
									res_status_q <= ST_BAD_PRICE;
								end else if (in_lvl.quantity == '0) begin
									res_status_q <= ST_BAD_QTY;
								end else if (!in_side && ask_used_q != '0 &&
								             in_lvl.price >= best_ask_q) begin
									res_status_q <= ST_CROSSED;
								end else if (in_side && bid_used_q != '0 &&
								             in_lvl.price <= best_bid_q) begin
									res_status_q <= ST_CROSSED;
								end else begin
									state_q <= S_SRCH;
								end
							end
							ACT_DELETE: begin
								is_rm_q <= 1'b1;
								state_q <= S_SRCH;
							end
							ACT_READ: begin
								nb_q    <= nb_c;
								na_q    <= na_c;
								rside_q <= 1'b0;
								ri_q    <= '0;
								if (nb_c == '0 && na_c == '0) begin
									res_side_q   <= 1'b0;
									res_status_q <= ST_EMPTY;
								end else begin
									state_q <= S_RD_ISS;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SRCH: begin
					if (j_q < used_sel) begin
						state_q <= S_SCMP;
					end else begin
						pos_q   <= j_q;
						match_q <= 1'b0;
						state_q <= S_DEC;
					end
				end
				S_SCMP: begin
					if (better) begin
						j_q     <= j_q + CW'(1);
						state_q <= S_SRCH;
					end else begin
						pos_q   <= j_q;
						match_q <= (rd_data_q.price == item_q.price);
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					dst_q <= pos_q;
					if (is_rm_q) begin
						state_q <= match_q ? S_SHD_RD : S_EMIT;
					end else if (match_q) begin
						state_q <= S_EMIT;
					end else if (used_sel == CW'(LEVELS)) begin
						res_status_q <= ST_FULL;
						state_q      <= S_EMIT;
					end else begin
						dst_q   <= used_sel;
						state_q <= S_SHU_RD;
					end
				end
				// Delete: pull each later level one rank toward the best.
				S_SHD_RD: begin
					if ((dst_q + CW'(1)) < used_sel) begin
						state_q <= S_SHD_WR;
					end else begin
						if (side_q) begin
							ask_used_q <= ask_used_q - CW'(1);
						end else begin
							bid_used_q <= bid_used_q - CW'(1);
						end
						state_q <= S_EMIT;
					end
				end
				S_SHD_WR: begin
					dst_q   <= dst_q + CW'(1);
					state_q <= S_SHD_RD;
				end
				// Insert: push later levels one rank back, then write the new one.
				S_SHU_RD: begin
					if (dst_q > pos_q) begin
						state_q <= S_SHU_WR;
					end else begin
						if (side_q) begin
							ask_used_q <= ask_used_q + CW'(1);
						end else begin
							bid_used_q <= bid_used_q + CW'(1);
						end
						state_q <= S_EMIT;
					end
				end
				S_SHU_WR: begin
					dst_q   <= dst_q - CW'(1);
					state_q <= S_SHU_RD;
				end
				S_EMIT: begin
					if (slot_free) begin
						if (res_cont_q) begin
							ri_q    <= ri_q + 5'd1;
							state_q <= S_RD_ISS;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				// Read: walk the bid levels, then the ask levels.
				S_RD_ISS: begin
					if (!rside_q && ri_q >= nb_q) begin
						rside_q <= 1'b1;
						ri_q    <= '0;
					end else begin
						state_q <= S_RD_WT;
					end
				end
				S_RD_WT: begin
					res_status_q <= ST_OK;
					res_side_q   <= rside_q;
					res_idx_q    <= ri_q[3:0];
					res_lvl_q    <= rd_data_q;
					if (rside_q) begin
						res_last_q <= (ri_q + 5'd1 == na_q);
						res_cont_q <= (ri_q + 5'd1 != na_q);
					end else begin
						res_last_q <= (ri_q + 5'd1 == nb_q) && (na_q == '0);
						res_cont_q <= !((ri_q + 5'd1 == nb_q) && (na_q == '0));
					end
					state_q <= S_EMIT;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A side never holds more than LEVELS levels.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bid_used_q <= CW'(LEVELS) && ask_used_q <= CW'(LEVELS))
		else $error("level count beyond capacity");

	// A clear empties both sides by the next edge.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_action == ACT_CLEAR |=> bid_used_q == '0 && ask_used_q == '0)
		else $error("clear did not empty the book");

	// A full status is reported only for a side at capacity.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT && res_status_q == ST_FULL |-> used_sel == CW'(LEVELS))
		else $error("side full reported below capacity");

	// The memory is never read and written in the same cycle.
	a_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("memory read and write collide");

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
	import plob_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH = 64;

	// One reported level or one outcome of the order book.
	typedef struct {
		logic [2:0]  status;
		logic        side;
		logic [3:0]  index;
		logic [31:0] price;
		logic [31:0] quantity;
		logic [15:0] orders;
		logic        last;
	} book_beat_t;

	// Predicts the book and checks every output beat against the oldest expectation.
	class book_scoreboard;
		logic [31:0] prc[2][DEPTH];
		logic [31:0] qty[2][DEPTH];
		logic [15:0] ord[2][DEPTH];
		int unsigned used[2];
		logic [4:0] depth_reg;
		book_beat_t pending[$];
		int errors;

		function new();
			used[0] = 0;
			used[1] = 0;
			depth_reg = TOP_DEPTH_RST;
			errors = 0;
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			$display("%0t: %s got %0h wanted %0h", $realtime, what, got, want);
		endtask

		// First rank whose price is not strictly better than p.
		function int unsigned rank_of(bit s, logic [31:0] p);
			int unsigned i;
			i = 0;
			while (i < used[s] && ((s == 0) ? (prc[s][i] > p) : (prc[s][i] < p)))
				i++;
			return i;
		endfunction

		function void drop_level(bit s, logic [31:0] p);
			int unsigned i;
			i = rank_of(s, p);
			if (i < used[s] && prc[s][i] == p) begin
				for (int unsigned j = i; j + 1 < used[s]; j++) begin
					prc[s][j] = prc[s][j+1];
					qty[s][j] = qty[s][j+1];
					ord[s][j] = ord[s][j+1];
				end
				used[s]--;
			end
		endfunction

		function logic [2:0] place_level(bit s, logic [31:0] p, logic [31:0] q,
				logic [15:0] c);
			int unsigned i;
			if (s == 0 && used[1] > 0 && p >= prc[1][0])
				return ST_CROSSED;
			if (s == 1 && used[0] > 0 && p <= prc[0][0])
				return ST_CROSSED;
			i = rank_of(s, p);
			if (i < used[s] && prc[s][i] == p) begin
				qty[s][i] = q;
				ord[s][i] = c;
				return ST_OK;
			end
			if (used[s] >= DEPTH)
				return ST_FULL;
			for (int unsigned j = used[s]; j > i; j--) begin
				prc[s][j] = prc[s][j-1];
				qty[s][j] = qty[s][j-1];
				ord[s][j] = ord[s][j-1];
			end
			prc[s][i] = p;
			qty[s][i] = q;
			ord[s][i] = c;
			used[s]++;
			return ST_OK;
		endfunction

		// Note an accepted input beat and queue the beats it causes.
		function void note_input(logic [2:0] act, bit s, logic [31:0] p, logic [31:0] q,
				logic [15:0] c);
			book_beat_t b;
			book_beat_t r;
			int unsigned n;
			int unsigned k;
			b = '{ST_OK, s, 4'd0, 32'd0, 32'd0, 16'd0, 1'b1};
			case (act)
				ACT_CLEAR: begin
					used[0] = 0;
					used[1] = 0;
					b.side = 1'b0;
				end
				ACT_SET: begin
					if (p == 0) b.status = ST_BAD_PRICE;
					else if (q == 0) b.status = ST_BAD_QTY;
					else b.status = place_level(s, p, q, c);
				end
				ACT_UPDATE: begin
					if (q == 0) drop_level(s, p);
					else if (p == 0) b.status = ST_BAD_PRICE;
					else b.status = place_level(s, p, q, c);
				end
				ACT_DELETE: drop_level(s, p);
				ACT_READ: begin
					n = (depth_reg == 0) ? 1 : (depth_reg > READ_MAX) ? READ_MAX : depth_reg;
					k = 0;
					for (int sd = 0; sd < 2; sd++)
						for (int unsigned i = 0; i < n && i < used[sd]; i++) begin
							r = '{ST_OK, sd[0], i[3:0], prc[sd][i],
								qty[sd][i], ord[sd][i], 1'b0};
							pending.insert(pending.size(), r);
							k++;
						end
					if (k == 0) begin
						b.status = ST_EMPTY;
						b.side = 1'b0;
					end else begin
						pending[pending.size()-1].last = 1'b1;
						return;
					end
				end
				default: ;
			endcase
			pending.insert(pending.size(), b);
		endfunction

		task check_output(book_beat_t g);
			book_beat_t w;
			if (pending.size() == 0) begin
				report("unexpected beat, status", g.status, 0);
				return;
			end
			w = pending[0];
			pending.delete(0);
			if (g.status !== w.status) report("status", g.status, w.status);
			if (g.side !== w.side) report("out_side", g.side, w.side);
			if (g.index !== w.index) report("level_index", g.index, w.index);
			if (g.price !== w.price) report("level_price", g.price, w.price);
			if (g.quantity !== w.quantity) report("level_quantity", g.quantity, w.quantity);
			if (g.orders !== w.orders) report("level_orders", g.orders, w.orders);
			if (g.last !== w.last) report("last", g.last, w.last);
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic [3:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [87:0] m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [4:0]  cfg_wdata = '0;

	book_scoreboard book;
	int hold_off = 0;
	bit steady_rx = 1'b0;
	logic [31:0] mid;

	price_level_order_book_top DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	// Receiver: stalls on its own random pattern, with a long hold-off on request.
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else if (steady_rx) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	// Check each accepted output beat.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			book.check_output('{m_tuser[2:0], m_tuser[3], m_tdata[3:0], m_tdata[35:4],
				m_tdata[67:36], m_tdata[83:68], m_tlast});
	end

	// Offer one beat and wait until it is accepted; valid stays up for the next one.
	task automatic send_beat(logic [2:0] act, bit s, logic [31:0] p, logic [31:0] q,
			logic [15:0] c);
		s_tvalid <= 1'b1;
		s_tuser <= {s, act};
		s_tdata <= {c, q, p};
		do @(posedge clk); while (!s_tready);
		book.note_input(act, s, p, q, c);
	endtask

	// Random gap between bursts.
	task automatic sender_gap();
		int n;
		n = $urandom_range(0, 6);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (book.pending.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic write_depth(logic [4:0] v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		book.depth_reg = v;
	endtask

	// Mostly well-formed updates near the current mid price, with some noise.
	task automatic random_burst(int count);
		logic [2:0] act;
		bit s;
		logic [31:0] p;
		logic [31:0] q;
		int burst;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			if (burst == 0) begin
				sender_gap();
				burst = $urandom_range(1, 12);
			end
			burst--;
			case ($urandom_range(0, 19))
				0: act = ACT_CLEAR;
				1, 2, 3, 4, 5: act = ACT_SET;
				6, 7, 8, 9, 10, 11: act = ACT_UPDATE;
				12, 13: act = ACT_DELETE;
				14, 15, 16: act = ACT_READ;
				default: act = 3'($urandom_range(0, 7));
			endcase
			s = 1'($urandom_range(0, 1));
			p = s ? mid + $urandom_range(1, 40) : mid - $urandom_range(1, 40);
			if ($urandom_range(0, 9) == 0) p = $urandom;
			if ($urandom_range(0, 19) == 0) p = 0;
			q = $urandom_range(0, 5) == 0 ? 32'd0 : $urandom;
			send_beat(act, s, p, q, 16'($urandom));
		end
	endtask

	initial begin
		book = new();
		mid = 32'h8000_0000;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty read, bad fields, extremes, crossing, deletes, ignored actions.
		send_beat(ACT_READ, 0, 0, 0, 0);
		send_beat(ACT_SET, 0, 0, 5, 1);
		send_beat(ACT_SET, 0, 100, 0, 1);
		send_beat(ACT_UPDATE, 1, 0, 7, 1);
		send_beat(ACT_UPDATE, 1, 0, 0, 1);
		send_beat(ACT_SET, 0, 1, 32'hFFFF_FFFF, 16'hFFFF);
		send_beat(ACT_SET, 1, 32'hFFFF_FFFF, 1, 0);
		send_beat(ACT_SET, 0, 500, 10, 3);
		send_beat(ACT_SET, 1, 500, 10, 3);
		send_beat(ACT_UPDATE, 0, 600, 10, 3);
		send_beat(ACT_SET, 1, 501, 20, 2);
		send_beat(ACT_UPDATE, 0, 500, 44, 9);
		send_beat(ACT_READ, 0, 0, 0, 0);
		send_beat(ACT_DELETE, 1, 777, 0, 0);
		send_beat(ACT_UPDATE, 0, 500, 0, 0);
		send_beat(ACT_DELETE, 1, 501, 0, 0);
		send_beat(3'd5, 1, 1, 1, 1);
		send_beat(3'd7, 0, 1, 1, 1);
		send_beat(ACT_READ, 1, 0, 0, 0);
		send_beat(ACT_CLEAR, 1, 0, 0, 0);
		send_beat(ACT_READ, 0, 0, 0, 0);

		// Fill the bid side to capacity, then a new price is refused.
		for (int i = 0; i < DEPTH + 1; i++)
			send_beat(ACT_SET, 0, 32'(1000 + i), 32'(i + 1), 16'(i));
		send_beat(ACT_UPDATE, 0, 1003, 9, 9);
		write_depth(5'd16);
		send_beat(ACT_READ, 0, 0, 0, 0);

		// Long receiver hold-off while the sender keeps offering.
		hold_off = 300;
		for (int i = 0; i < 6; i++) send_beat(ACT_READ, 0, 0, 0, 0);
		wait_drained();
		send_beat(ACT_CLEAR, 0, 0, 0, 0);

		// Random phases across register settings.
		write_depth(5'd0);
		random_burst(30);
		write_depth(5'd31);
		random_burst(30);
		steady_rx = 1'b1;
		write_depth(5'd1);
		random_burst(25);
		steady_rx = 1'b0;
		write_depth(5'd7);
		mid = 32'd50;
		random_burst(25);
		write_depth(5'd16);
		random_burst(25);

		wait_drained();
		if (book.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#4ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
